// ===== hdl/grid_bfs_shortest_path_unit_macros.svh =====
// ----------------------------------------------------------------------------
// grid bfs shortest path unit: assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define GBSP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define GBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define GBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbsp_pkg
// Types and constants shared by the grid search unit and its neighbour step unit.
// ----------------------------------------------------------------------------
package gbsp_pkg;

    // default grid bounds
    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_COLS_DEF = 128;

    // field and configuration widths
    localparam int OUT_W     = 15;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // neighbour directions, in search order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_LOAD  = 3'd1,
        ST_POP   = 3'd2,
        ST_FETCH = 3'd3,
        ST_NBR   = 3'd4,
        ST_DONE  = 3'd5,
        ST_SWEEP = 3'd6
    } t_state;

endpackage

// ===== hdl/grid_bfs_shortest_path_unit.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_unit
// Breadth-first shortest path through a loaded maze, start top-left,
// goal bottom-right, four-neighbour moves.
//
// Usage
//   Configure rows and cols on the write port (index 0 and 1); any such write
//   restarts the grid load at cell 0. Sizes of 0 act as 1, sizes above the
//   maximum act as the maximum.
//   Input channel: one cell_open bit per transfer, row-major, one transfer a
//   cycle while loading. The transfer of the last cell starts the search and
//   o_in_stall stays high until the search and its clean-up have finished.
//   Search: each cell taken from the frontier queue goes through a queue read,
//   a fetch and four neighbour reads overlapped with the checks, as the visited
//   and open maps each have a single read port; it stops early once the goal
//   is reached. Clean-up then walks the queue, one entry per cycle.
//   Output channel: one path_cells transfer per grid, held in an output
//   register; a stalled result does not block the next load.
//   Reset: the visited map is cleared by a pass over all 2^(RW+CW) addresses
//   (16384 at default sizes), during which no cell is taken; configuration
//   writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path_unit import gbsp_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cell_open,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_W-1:0]     o_path_cells
);

`include "grid_bfs_shortest_path_unit_macros.svh"

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int AW   = RW + CW;
    localparam int MW   = (RW > CW) ? RW : CW;
    localparam int QD   = MAX_ROWS * MAX_COLS;
    localparam int QW   = $clog2(QD);
    localparam int EW   = OUT_W + AW;
    localparam int DIMW = ((MW + 1) > CFG_W) ? (MW + 1) : CFG_W;

    // registers
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows, n_rows;
    logic [CFG_W-1:0]  r_cols, n_cols;
    logic [RW-1:0]     r_ld_row, n_ld_row;
    logic [CW-1:0]     r_ld_col, n_ld_col;
    logic [AW-1:0]     r_clr, n_clr;
    logic [QW:0]       r_head, n_head;
    logic [QW:0]       r_tail, n_tail;
    logic [2:0]        r_k, n_k;
    logic              r_chk_vld, n_chk_vld;
    logic              r_found, n_found;
    logic              r_sw_pend, n_sw_pend;
    logic              r_out_vld, n_out_vld;
    logic [OUT_W-1:0]  r_cur_dist, n_cur_dist;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic [RW-1:0]     r_chk_row, n_chk_row;
    logic [CW-1:0]     r_chk_col, n_chk_col;
    logic [OUT_W-1:0]  r_result, n_result;
    logic [QW:0]       r_sw, n_sw;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    // combinational
    logic [DIMW-1:0]   w_rows_ext, w_rows_cl;
    logic [DIMW-1:0]   w_cols_ext, w_cols_cl;
    logic [RW-1:0]     w_last_row;
    logic [CW-1:0]     w_last_col;
    logic              w_in_take;
    logic              w_out_take;
    logic [OUT_W-1:0]  w_dsat;
    logic              w_nb_vld;
    logic [RW-1:0]     w_nb_row;
    logic [CW-1:0]     w_nb_col;

    // memory ports
    logic              w_open_we, w_open_rdata;
    logic              w_vis_we, w_vis_wdata, w_vis_rdata;
    logic [AW-1:0]     w_vis_waddr;
    logic              w_q_we;
    logic [QW-1:0]     w_q_waddr, w_q_raddr;
    logic [EW-1:0]     w_q_wdata, w_q_rdata;

    // clamped grid size as last row and column index
    always_comb begin
        w_rows_ext = DIMW'(r_rows);
        w_cols_ext = DIMW'(r_cols);
        if (w_rows_ext == '0) begin
            w_rows_cl = DIMW'(1);
        end else if (w_rows_ext > DIMW'(MAX_ROWS)) begin
            w_rows_cl = DIMW'(MAX_ROWS);
        end else begin
            w_rows_cl = w_rows_ext;
        end
        if (w_cols_ext == '0) begin
            w_cols_cl = DIMW'(1);
        end else if (w_cols_ext > DIMW'(MAX_COLS)) begin
            w_cols_cl = DIMW'(MAX_COLS);
        end else begin
            w_cols_cl = w_cols_ext;
        end
        w_last_row = RW'(w_rows_cl - DIMW'(1));
        w_last_col = CW'(w_cols_cl - DIMW'(1));
    end

    // handshakes
    assign o_in_stall   = (r_state != ST_LOAD);
    assign w_in_take    = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_out_vld;
    assign o_path_cells = r_out_data;
    assign w_out_take   = r_out_vld && !i_out_stall;

    // saturating distance of a newly reached neighbour
    assign w_dsat = (r_cur_dist == '1) ? r_cur_dist : r_cur_dist + OUT_W'(1);

    // shared neighbour step unit
    gbsp_nbr #(
        .RW (RW),
        .CW (CW)
    ) u_nbr (
        .i_dir      (t_dir'(r_k[1:0])),
        .i_row      (r_cur_row),
        .i_col      (r_cur_col),
        .i_last_row (w_last_row),
        .i_last_col (w_last_col),
        .o_valid    (w_nb_vld),
        .o_row      (w_nb_row),
        .o_col      (w_nb_col)
    );

    // open map, written while loading
    gbsp_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_open_ram (
        .i_clk   (i_clk),
        .i_we    (w_open_we),
        .i_waddr ({r_ld_row, r_ld_col}),
        .i_wdata (i_cell_open),
        .i_raddr ({w_nb_row, w_nb_col}),
        .o_rdata (w_open_rdata)
    );

    // visited map
    gbsp_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr ({w_nb_row, w_nb_col}),
        .o_rdata (w_vis_rdata)
    );

    // frontier queue: {distance, row, col}
    gbsp_ram #(
        .WIDTH (EW),
        .DEPTH (QD)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    // sequencer: next state, counters and memory controls
    always_comb begin
        n_state    = r_state;
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_ld_row   = r_ld_row;
        n_ld_col   = r_ld_col;
        n_clr      = r_clr;
        n_head     = r_head;
        n_tail     = r_tail;
        n_k        = r_k;
        n_chk_vld  = r_chk_vld;
        n_found    = r_found;
        n_sw_pend  = r_sw_pend;
        n_out_vld  = r_out_vld;
        n_cur_dist = r_cur_dist;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_chk_row  = r_chk_row;
        n_chk_col  = r_chk_col;
        n_result   = r_result;
        n_sw       = r_sw;
        n_out_data = r_out_data;

        w_open_we   = 1'b0;
        w_vis_we    = 1'b0;
        w_vis_waddr = {r_chk_row, r_chk_col};
        w_vis_wdata = 1'b1;
        w_q_we      = 1'b0;
        w_q_waddr   = r_tail[QW-1:0];
        w_q_wdata   = {w_dsat, r_chk_row, r_chk_col};
        w_q_raddr   = r_head[QW-1:0];

        // result leaves the output register
        if (w_out_take) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            // visited map clearing pass after reset
            ST_CLEAR: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr;
                w_vis_wdata = 1'b0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_LOAD;
                end
            end
            // grid load, one cell per transfer
            ST_LOAD: begin
                if (w_in_take) begin
                    w_open_we = 1'b1;
                    if (r_ld_col == w_last_col) begin
                        n_ld_col = '0;
                        if (r_ld_row == w_last_row) begin
                            // last cell: seed the search with the start cell
                            n_ld_row    = '0;
                            w_vis_we    = 1'b1;
                            w_vis_waddr = '0;
                            w_vis_wdata = 1'b1;
                            w_q_we      = 1'b1;
                            w_q_waddr   = '0;
                            w_q_wdata   = {OUT_W'(1), {AW{1'b0}}};
                            n_head      = '0;
                            n_tail      = (QW + 1)'(1);
                            n_chk_vld   = 1'b0;
                            if ((w_last_row == '0) && (w_last_col == '0)) begin
                                n_found  = 1'b1;
                                n_result = OUT_W'(1);
                                n_state  = ST_DONE;
                            end else begin
                                n_found  = 1'b0;
                                n_result = '0;
                                n_state  = ST_POP;
                            end
                        end else begin
                            n_ld_row = r_ld_row + RW'(1);
                        end
                    end else begin
                        n_ld_col = r_ld_col + CW'(1);
                    end
                end
            end
            // take the next cell off the frontier
            ST_POP: begin
                if (r_head == r_tail) begin
                    n_state = ST_DONE;
                end else begin
                    w_q_raddr = r_head[QW-1:0];
                    n_head    = r_head + (QW + 1)'(1);
                    n_state   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                {n_cur_dist, n_cur_row, n_cur_col} = w_q_rdata;
                n_k       = '0;
                n_chk_vld = 1'b0;
                n_state   = ST_NBR;
            end
            // read neighbour k while checking neighbour k-1
            ST_NBR: begin
                if (r_k != 3'd4) begin
                    n_chk_vld = w_nb_vld;
                    n_chk_row = w_nb_row;
                    n_chk_col = w_nb_col;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld && w_open_rdata && !w_vis_rdata) begin
                    w_vis_we = 1'b1;
                    w_q_we   = 1'b1;
                    n_tail   = r_tail + (QW + 1)'(1);
                    if ({r_chk_row, r_chk_col} == {w_last_row, w_last_col}) begin
                        n_found  = 1'b1;
                        n_result = w_dsat;
                    end
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = n_found ? ST_DONE : ST_POP;
                end
            end
            // hand the result to the output register
            ST_DONE: begin
                if (!r_out_vld || w_out_take) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_result;
                    n_sw       = '0;
                    n_sw_pend  = 1'b0;
                    n_state    = ST_SWEEP;
                end
            end
            // clear the visited marks of every queued cell
            ST_SWEEP: begin
                if (r_sw != r_tail) begin
                    w_q_raddr = r_sw[QW-1:0];
                    n_sw      = r_sw + (QW + 1)'(1);
                    n_sw_pend = 1'b1;
                end else begin
                    n_sw_pend = 1'b0;
                end
                if (r_sw_pend) begin
                    w_vis_we    = 1'b1;
                    w_vis_waddr = w_q_rdata[AW-1:0];
                    w_vis_wdata = 1'b0;
                end
                if ((r_sw == r_tail) && !r_sw_pend) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        // configuration writes restart the load
        if (i_cfg_we) begin
            if (i_cfg_idx == REG_ROWS) begin
                n_rows   = i_cfg_data;
                n_ld_row = '0;
                n_ld_col = '0;
            end else if (i_cfg_idx == REG_COLS) begin
                n_cols   = i_cfg_data;
                n_ld_row = '0;
                n_ld_col = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_rows    <= CFG_W'(1);
            r_cols    <= CFG_W'(1);
            r_ld_row  <= '0;
            r_ld_col  <= '0;
            r_clr     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_k       <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
            r_sw_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_ld_row  <= n_ld_row;
            r_ld_col  <= n_ld_col;
            r_clr     <= n_clr;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_k       <= n_k;
            r_chk_vld <= n_chk_vld;
            r_found   <= n_found;
            r_sw_pend <= n_sw_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_dist <= n_cur_dist;
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_chk_row  <= n_chk_row;
        r_chk_col  <= n_chk_col;
        r_result   <= n_result;
        r_sw       <= n_sw;
        r_out_data <= n_out_data;
    end

    // checks
    `GBSP_ASSERT_ALWAYS(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail, "queue head past tail")
    `GBSP_ASSERT_ALWAYS(a_tail_bound, i_clk, i_rst_n, r_tail <= (QW + 1)'(QD), "queue overflow")
    `GBSP_ASSERT_IMPL(a_found_result, i_clk, i_rst_n, r_state == ST_DONE, r_found == (r_result != '0), "result and found flag disagree")
    `GBSP_ASSERT_NEXT(a_done_hands_off, i_clk, i_rst_n, (r_state == ST_DONE) && (!r_out_vld || !i_out_stall), r_out_vld && (r_state == ST_SWEEP), "result not handed to output")

endmodule

// ===== hdl/gbsp_ram.sv =====
// ----------------------------------------------------------------------------
// gbsp_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gbsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gbsp_nbr.sv =====
// ----------------------------------------------------------------------------
// gbsp_nbr
// Neighbour step unit: one shared increment/decrement and bound compare
// that turns a cell and a direction into the neighbour cell.
// ----------------------------------------------------------------------------
module gbsp_nbr import gbsp_pkg::*; #(
    parameter int RW = 7,
    parameter int CW = 7
) (
    input  t_dir          i_dir,
    input  logic [RW-1:0] i_row,
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_last_row,
    input  logic [CW-1:0] i_last_col,
    output logic          o_valid,
    output logic [RW-1:0] o_row,
    output logic [CW-1:0] o_col
);

    localparam int MW = (RW > CW) ? RW : CW;

    logic          w_vert;
    logic          w_dec;
    logic [MW-1:0] w_sel;
    logic [MW-1:0] w_lim;
    logic [MW-1:0] w_res;

    // pick the moving coordinate, then step it by one inside the grid
    always_comb begin
        w_vert = (i_dir == DIR_UP) || (i_dir == DIR_DOWN);
        w_dec  = (i_dir == DIR_UP) || (i_dir == DIR_LEFT);
        w_sel  = w_vert ? MW'(i_row) : MW'(i_col);
        w_lim  = w_vert ? MW'(i_last_row) : MW'(i_last_col);
        if (w_dec) begin
            o_valid = (w_sel != '0);
            w_res   = w_sel - MW'(1);
        end else begin
            o_valid = (w_sel != w_lim);
            w_res   = w_sel + MW'(1);
        end
        o_row = w_vert ? RW'(w_res) : i_row;
        o_col = w_vert ? i_col : CW'(w_res);
    end

endmodule
